FILE: rtl/core/nte_pkg.sv
// Shared types and constants for the negacyclic NTT evaluator.
// No dependencies; every other file in rtl/core imports this package.
package nte_pkg;

    localparam int RING_DEGREE_DEF = 256;
    localparam int ADDR_W          = 18;   // wide enough for 2N up to 131072
    localparam int INDEX_W         = 9;
    localparam int WORD_W          = 64;
    localparam int MOD_W           = 62;
    localparam int SLOT_W          = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PIPE_STAGES     = 9;

    typedef enum logic [1:0] {
        FUNC_ROOT  = 2'd0,
        FUNC_COEF  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_MODULUS = 2'd0,
        CFG_BAR_HI  = 2'd1,
        CFG_BAR_LO  = 2'd2,
        CFG_NONE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_ROOT = 2'd0,
        CMD_COEF = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_DONE
    } t_bk_state;

    // Sum of four 32x32 partial products into the full 128-bit product.
    function automatic logic [127:0] mul_combine(input logic [63:0] p00, input logic [63:0] p01,
                                                 input logic [63:0] p10, input logic [63:0] p11);
        mul_combine = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    endfunction

endpackage

FILE: rtl/core/nte_front.sv
// Input front end: decodes incoming words into queue commands.
// Depends on nte_pkg.
module nte_front
    import nte_pkg::*;
#(
    parameter int RING_DEGREE = RING_DEGREE_DEF
) (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [WORD_W-1:0]  i_value,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam logic [ADDR_W-1:0] N_LIM  = ADDR_W'(RING_DEGREE);
    localparam logic [ADDR_W-1:0] N2_LIM = ADDR_W'(2 * RING_DEGREE);

    logic [ADDR_W-1:0] idx_ext;
    logic              keep;

    assign idx_ext = ADDR_W'(i_index);
    assign o_ready = !i_full;

    // Out-of-range writes and the unused code are accepted and dropped here.
    always_comb begin
        keep        = 1'b0;
        o_cmd.kind  = CMD_NOP;
        o_cmd.addr  = idx_ext;
        o_cmd.value = i_value;
        unique case (t_func'(i_func))
            FUNC_ROOT: begin
                o_cmd.kind = CMD_ROOT;
                keep       = (idx_ext < N2_LIM);
            end
            FUNC_COEF: begin
                o_cmd.kind = CMD_COEF;
                keep       = (idx_ext < N_LIM);
            end
            FUNC_READ: begin
                o_cmd.kind = CMD_READ;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule

FILE: rtl/core/nte_queue.sv
// Short command queue between the front end and the back end.
// Depends on nte_pkg.
module nte_queue
    import nte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

FILE: rtl/core/nte_mulred.sv
// Pipelined 64x64 multiply with Barrett reduction modulo q.
// Depends on nte_pkg; all products are 32x32 and registered.
module nte_mulred
    import nte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic [WORD_W-1:0] i_bar_hi,
    input  logic [WORD_W-1:0] i_bar_lo,
    output t_tag              o_tag,
    output logic [WORD_W-1:0] o_rem
);

    t_tag         r_tag [PIPE_STAGES];
    logic [63:0]  r1_p [4];
    logic [127:0] r2_x;
    logic [63:0]  r3_q [4][4];
    logic [63:0]  r4_llh, r4_lhh, r4_lhl, r4_hlh, r4_hll, r4_hhl, r4_xl;
    logic [63:0]  r3_xl, r5_est, r5_xl, r6_xl, r6_a;
    logic [31:0]  r6_b, r6_c;
    logic [63:0]  r7_r, r8_r, r9_r;
    logic [63:0]  ops_x [4];
    logic [63:0]  ops_m [4];
    logic [127:0] prod [4];
    logic [65:0]  mid;
    logic [63:0]  q64;

    assign q64 = WORD_W'(i_modulus);

    // Operand pairs for the four Barrett products: xl*ml, xl*mh, xh*ml, xh*mh.
    always_comb begin
        ops_x[0] = r2_x[63:0];   ops_m[0] = i_bar_lo;
        ops_x[1] = r2_x[63:0];   ops_m[1] = i_bar_hi;
        ops_x[2] = r2_x[127:64]; ops_m[2] = i_bar_lo;
        ops_x[3] = r2_x[127:64]; ops_m[3] = i_bar_hi;
        for (int k = 0; k < 4; k++) begin
            prod[k] = mul_combine(r3_q[k][0], r3_q[k][1], r3_q[k][2], r3_q[k][3]);
        end
        mid = {2'b00, r4_llh} + {2'b00, r4_lhl} + {2'b00, r4_hll};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_STAGES; s++) r_tag[s] <= '0;
        end else begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < PIPE_STAGES; s++) r_tag[s] <= r_tag[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p[0] <= i_a[31:0]  * i_b[31:0];
        r1_p[1] <= i_a[31:0]  * i_b[63:32];
        r1_p[2] <= i_a[63:32] * i_b[31:0];
        r1_p[3] <= i_a[63:32] * i_b[63:32];
        r2_x    <= mul_combine(r1_p[0], r1_p[1], r1_p[2], r1_p[3]);
        for (int k = 0; k < 4; k++) begin
            r3_q[k][0] <= ops_x[k][31:0]  * ops_m[k][31:0];
            r3_q[k][1] <= ops_x[k][31:0]  * ops_m[k][63:32];
            r3_q[k][2] <= ops_x[k][63:32] * ops_m[k][31:0];
            r3_q[k][3] <= ops_x[k][63:32] * ops_m[k][63:32];
        end
        r3_xl  <= r2_x[63:0];
        r4_llh <= prod[0][127:64];
        r4_lhh <= prod[1][127:64];
        r4_lhl <= prod[1][63:0];
        r4_hlh <= prod[2][127:64];
        r4_hll <= prod[2][63:0];
        r4_hhl <= prod[3][63:0];
        r4_xl  <= r3_xl;
        r5_est <= r4_hhl + r4_lhh + r4_hlh + 64'(mid[65:64]);
        r5_xl  <= r4_xl;
        r6_a   <= r5_est[31:0] * q64[31:0];
        r6_b   <= 32'(r5_est[63:32] * q64[31:0]);
        r6_c   <= 32'(r5_est[31:0] * q64[63:32]);
        r6_xl  <= r5_xl;
        r7_r   <= r6_xl - (r6_a + {r6_b + r6_c, 32'd0});
        r8_r   <= (r7_r >= q64) ? r7_r - q64 : r7_r;
        r9_r   <= (r8_r >= q64) ? r8_r - q64 : r8_r;
    end

    assign o_tag = r_tag[PIPE_STAGES-1];
    assign o_rem = r9_r;

endmodule

FILE: rtl/core/nte_back.sv
// Back end: table stores, read sequencer, accumulator and result register.
// Depends on nte_pkg and nte_mulred.
module nte_back
    import nte_pkg::*;
#(
    parameter int RING_DEGREE = RING_DEGREE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic [WORD_W-1:0] i_bar_hi,
    input  logic [WORD_W-1:0] i_bar_lo,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SLOT_W-1:0] o_slot,
    output logic [MOD_W-1:0]  o_eval
);

    localparam int LOG_N = $clog2(RING_DEGREE);
    localparam logic [ADDR_W-1:0] SLOT_MASK = ADDR_W'(RING_DEGREE - 1);
    localparam logic [LOG_N:0]    LAST_J    = (LOG_N+1)'(RING_DEGREE - 1);

    logic [WORD_W-1:0] r_root [2*RING_DEGREE];
    logic [WORD_W-1:0] r_coef [RING_DEGREE];

    t_bk_state         r_state, n_state;
    logic [LOG_N:0]    r_j, r_m, r_step;
    logic [ADDR_W-1:0] r_slot;
    logic [WORD_W-1:0] r_sum, r_rd_root, r_rd_coef;
    t_tag              r_rd_tag;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [MOD_W-1:0]  r_out_eval;

    logic              start_read, do_write, issue, load_out;
    logic [ADDR_W-1:0] slot_w;
    logic [LOG_N-1:0]  krev;
    t_tag              mr_tag;
    logic [WORD_W-1:0] mr_rem, acc, q64;

    assign slot_w = i_cmd.addr & SLOT_MASK;
    assign q64    = WORD_W'(i_modulus);

    always_comb begin
        for (int b = 0; b < LOG_N; b++) krev[b] = slot_w[LOG_N-1-b];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (!i_empty && i_cmd.kind == CMD_READ) n_state = BK_ISSUE;
            BK_ISSUE: if (r_j == LAST_J) n_state = BK_DRAIN;
            BK_DRAIN: if (mr_tag.valid && mr_tag.last) n_state = BK_DONE;
            BK_DONE:  if (!r_out_valid || i_ready) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop      = 1'b0;
        start_read = 1'b0;
        do_write   = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop      = !i_empty;
                start_read = !i_empty && (i_cmd.kind == CMD_READ);
                do_write   = !i_empty && (i_cmd.kind != CMD_READ);
            end
            BK_ISSUE: issue    = 1'b1;
            BK_DRAIN: ;
            BK_DONE:  load_out = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_write && i_cmd.kind == CMD_ROOT) r_root[i_cmd.addr[LOG_N:0]] <= i_cmd.value;
        if (do_write && i_cmd.kind == CMD_COEF) r_coef[i_cmd.addr[LOG_N-1:0]] <= i_cmd.value;
        r_rd_root <= r_root[r_m];
        r_rd_coef <= r_coef[r_j[LOG_N-1:0]];
    end

    nte_mulred u_mulred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (r_rd_tag),
        .i_a       (r_rd_coef),
        .i_b       (r_rd_root),
        .i_modulus (i_modulus),
        .i_bar_hi  (i_bar_hi),
        .i_bar_lo  (i_bar_lo),
        .o_tag     (mr_tag),
        .o_rem     (mr_rem)
    );

    always_comb begin
        acc = r_sum + mr_rem;
        if (acc >= q64) acc = acc - q64;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rd_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_tag.valid <= issue;
            r_rd_tag.last  <= issue && (r_j == LAST_J);
            if (load_out)                  r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_read) begin
            r_slot <= slot_w;
            r_step <= {krev, 1'b1};
            r_j    <= '0;
            r_m    <= '0;
            r_sum  <= '0;
        end else begin
            if (issue) begin
                r_j <= r_j + 1'b1;
                r_m <= r_m + r_step;
            end
            if (mr_tag.valid) r_sum <= acc;
        end
        if (load_out) begin
            r_out_slot <= r_slot[SLOT_W-1:0];
            r_out_eval <= r_sum[MOD_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_slot  = r_out_slot;
    assign o_eval  = r_out_eval;

endmodule

FILE: rtl/core/negacyclic_ntt_evaluator.sv
// Top level of the negacyclic NTT evaluator: configuration registers and
// the front end, command queue and back end. Depends on nte_pkg and all nte_* modules.
//
//   Channel   Direction  Contents (lowest bit first)
//   s_axis    in         tuser: func[1:0]; tdata: index[8:0], value[72:9], zero pad
//   m_axis    out        tdata: slot[7:0], evaluation[69:8], zero pad
//   cfg       in         i_cfg_we, i_cfg_idx (register index), i_cfg_data
//
// Load words are written into their table in the same cycle that they leave the queue.
// For a read word, one coefficient/root pair is fed per cycle into the
// multiply-reduce pipeline, which is nine stages deep.
// The queue keeps taking words while the back end works, until it is full.
// Reset is synchronous and active low; it clears control state only, and the
// tables hold nothing defined until written.
module negacyclic_ntt_evaluator
    import nte_pkg::*;
#(
    parameter int RING_DEGREE = RING_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // index[8:0], value[72:9], zero pad
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // slot[7:0], evaluation[69:8], zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [MOD_W-1:0]  r_modulus;
    logic [WORD_W-1:0] r_bar_hi, r_bar_lo;

    logic              push, full, empty, pop;
    t_cmd              push_cmd, head_cmd;
    logic [SLOT_W-1:0] out_slot;
    logic [MOD_W-1:0]  out_eval;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_W'(3);
            r_bar_hi  <= '0;
            r_bar_lo  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODULUS: r_modulus <= i_cfg_data[MOD_W-1:0];
                CFG_BAR_HI:  r_bar_hi  <= i_cfg_data;
                CFG_BAR_LO:  r_bar_lo  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nte_front #(.RING_DEGREE(RING_DEGREE)) u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_func  (s_axis_tuser),
        .i_index (s_axis_tdata[8:0]),
        .i_value (s_axis_tdata[72:9]),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    nte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    nte_back #(.RING_DEGREE(RING_DEGREE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .i_modulus (r_modulus),
        .i_bar_hi  (r_bar_hi),
        .i_bar_lo  (r_bar_lo),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_slot    (out_slot),
        .o_eval    (out_eval)
    );

    assign m_axis_tdata = {2'b00, out_eval, out_slot};

endmodule

FILE: dv/negacyclic_ntt_evaluator_test.sv
// Self-checking testbench for the negacyclic NTT evaluator: loads the root and
// coefficient tables, reads slots under several moduli and compares the results.
// Depends on nte_pkg and the evaluator RTL only.
module negacyclic_ntt_evaluator_test;
    import nte_pkg::*;

    localparam int N        = 256;
    localparam int SETTLE   = 320;
    localparam int MAX_GAP  = 13;

    typedef struct packed {
        logic [7:0]  slot;
        logic [61:0] evaluation;
    } t_eval;

    // Scoreboard with its own copy of the tables and the reduction constants.
    // Each accepted read word queues the evaluation it must produce.
    class eval_scoreboard;
        logic [63:0] roots [2*N];
        logic [63:0] coefs [N];
        logic [63:0] q;
        logic [63:0] bar_hi;
        logic [63:0] bar_lo;
        t_eval       pending_evals [$];
        int          fails;
        int          evals_checked;

        function new();
            q      = 64'd3;
            bar_hi = '0;
            bar_lo = '0;
            fails  = 0;
            evals_checked = 0;
        endfunction

        function void set_reg(t_cfg_idx r, logic [63:0] d);
            case (r)
                CFG_MODULUS: q = {2'b00, d[61:0]};
                CFG_BAR_HI:  bar_hi = d;
                CFG_BAR_LO:  bar_lo = d;
                default: ;
            endcase
        endfunction

        // Full product, Barrett estimate taken as bits 191:128 of x * m, then
        // the low 64-bit remainder with two conditional subtracts.
        function logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b);
            logic [127:0] x;
            logic [255:0] p;
            logic [63:0]  est;
            logic [63:0]  r;
            x   = {64'd0, a} * {64'd0, b};
            p   = {128'd0, x} * {128'd0, bar_hi, bar_lo};
            est = p[191:128];
            r   = x[63:0] - est * q;
            if (r >= q) r = r - q;
            if (r >= q) r = r - q;
            return r;
        endfunction

        function void note_word(t_func f, logic [8:0] idx, logic [63:0] v);
            logic [7:0]  slot;
            logic [7:0]  k;
            logic [63:0] sum;
            logic [8:0]  step;
            logic [8:0]  m;
            t_eval       expected;
            if (f == FUNC_ROOT) begin
                roots[idx] = v;
            end else if (f == FUNC_COEF) begin
                if (idx < N) coefs[idx[7:0]] = v;
            end else if (f == FUNC_READ) begin
                slot = idx[7:0];
                for (int b = 0; b < 8; b++) k[b] = slot[7-b];
                step = {k, 1'b1};
                sum  = '0;
                for (int j = 0; j < N; j++) begin
                    m   = step * j[8:0];
                    sum = sum + mul_reduce(coefs[j], roots[m]);
                    if (sum >= q) sum = sum - q;
                end
                expected.slot       = slot;
                expected.evaluation = sum[61:0];
                pending_evals = {pending_evals, expected};
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_eval(logic [7:0] slot, logic [61:0] evaluation);
            t_eval e;
            if (pending_evals.size() == 0) begin
                report($sformatf("unexpected word slot=%0d evaluation=%0h", slot, evaluation));
            end else begin
                e = pending_evals.pop_front();
                evals_checked++;
                if (slot !== e.slot)
                    report($sformatf("slot %0d, expected %0d", slot, e.slot));
                if (evaluation !== e.evaluation)
                    report($sformatf("slot %0d evaluation %0h, expected %0h",
                                     e.slot, evaluation, e.evaluation));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;     // index[8:0], value[72:9], zero pad
    logic [1:0]  s_axis_tuser = '0;     // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // slot[7:0], evaluation[69:8], zero pad
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    eval_scoreboard sb = new();
    bit  no_gaps;          // when set, both sides run back to back
    int  words_sent;

    negacyclic_ntt_evaluator dut (.*);

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #20_000_000;
        $display("timeout with %0d evaluations outstanding", sb.pending_evals.size());
        $display("simulation failed");
        $finish;
    end

    function int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} % sb.q;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Called right after a rising edge. Valid is only lowered when a gap is drawn,
    // so back-to-back words keep it high across the edge.
    task send_word(t_func f, logic [8:0] idx, logic [63:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {7'd0, v, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(f, idx, v);
        words_sent++;
    endtask

    // Drops valid, waits until every evaluation has come back, then lets the
    // back end finish any load words still queued behind the last read.
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_evals.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx r, logic [63:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(r, d);
    endtask

    // Modulus with its Barrett constant, or deliberately wrong constants.
    task set_modulus(logic [63:0] q, bit consistent);
        logic [127:0] m;
        m = {128{1'b1}} / {64'd0, 2'b00, q[61:0]};
        if (!consistent) m = {$urandom, $urandom, $urandom, $urandom};
        write_reg(CFG_MODULUS, q);
        write_reg(CFG_BAR_HI, m[127:64]);
        write_reg(CFG_BAR_LO, m[63:0]);
        write_reg(CFG_NONE, {$urandom, $urandom});
    endtask

    // Receiver: random stalls, occasionally none at all.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_eval(m_axis_tdata[7:0], m_axis_tdata[69:8]);
        end
    end

    initial begin
        logic [63:0] moduli [6];
        int          r;
        words_sent = 0;
        no_gaps    = 1'b0;
        // Smallest odd prime, a mid prime, a prime just under 2^62, the largest
        // 62-bit value, the 998244353 prime, then one with bogus constants.
        moduli[0] = 64'd3;
        moduli[1] = 64'd65537;
        moduli[2] = 64'h3FFF_FFFF_FFFF_FFC7;
        moduli[3] = 64'hFFFF_FFFF_FFFF_FFFF;   // top bits must be dropped
        moduli[4] = 64'd998244353;
        moduli[5] = 64'h2000_0000_0000_0001;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill both tables completely before any read; extremes come from rand_word.
        for (int i = 0; i < 2 * N; i++) send_word(FUNC_ROOT, i[8:0], rand_word());
        for (int i = 0; i < N; i++) send_word(FUNC_COEF, i[8:0], rand_word());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_modulus(moduli[ph], ph != 5);

            // Directed words: extreme slots, wrapping slot indices, ignored
            // coefficient writes, and the unused function code.
            send_word(FUNC_READ, 9'd0, rand_word());
            send_word(FUNC_READ, 9'd255, rand_word());
            send_word(FUNC_READ, 9'd256, '1);
            send_word(FUNC_READ, 9'd511, '0);
            send_word(FUNC_COEF, 9'd300, '1);
            send_word(FUNC_COEF, 9'd511, '1);
            send_word(FUNC_NONE, 9'd5, '1);
            send_word(FUNC_ROOT, 9'd511, rand_word());
            send_word(FUNC_COEF, 9'd255, '1);
            send_word(FUNC_READ, 9'd128, rand_word());

            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
                r = $urandom_range(0, 9);
                if (r < 3)
                    send_word(FUNC_READ, 9'($urandom), {$urandom, $urandom});
                else if (r < 6)
                    send_word(FUNC_ROOT, 9'($urandom), rand_word());
                else if (r < 9)
                    send_word(FUNC_COEF, 9'($urandom), rand_word());
                else
                    send_word(FUNC_NONE, 9'($urandom), {$urandom, $urandom});
            end
            no_gaps = 1'b0;
            drain();
        end

        $display("Sent %0d words over 6 modulus settings; %0d evaluations compared.",
                 words_sent, sb.evals_checked);
        if (sb.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.fails);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
